FILE: rtl/core/pidc_pkg.sv
// Shared types and constants for the PID position/increment controller.
`timescale 1ns / 1ps
`default_nettype none

package pidc_pkg;

    localparam int GAIN_W         = 16;
    localparam int SET_W          = 16;
    localparam int OUT_W          = 32;
    localparam int CFG_DATA_W     = 16;
    localparam int CFG_INDEX_W    = 3;
    localparam int GAIN_FRAC_BITS = 8;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_MODE     = 3'd0,
        REG_SETPOINT = 3'd1,
        REG_KP_GAIN  = 3'd2,
        REG_KI_GAIN  = 3'd3,
        REG_KD_GAIN  = 3'd4
    } cfg_reg_t;

    typedef enum logic {
        MODE_INCREMENTAL = 1'b0,
        MODE_POSITIONAL  = 1'b1
    } pid_mode_t;

endpackage

`default_nettype wire

FILE: rtl/core/pidc_if.sv
// Item channel interfaces for the PID controller: sample in, control value out.
`timescale 1ns / 1ps
`default_nettype none

interface pidc_in_if #(
    parameter int SAMPLE_BITS = 16
) ();
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] measurement;

    modport source (output valid, output measurement, input ready);
    modport sink   (input valid, input measurement, output ready);
endinterface

interface pidc_out_if import pidc_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic signed [OUT_W-1:0] control_value;
    logic                    saturated;

    modport source (output valid, output control_value, output saturated, input ready);
    modport sink   (input valid, input control_value, input saturated, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/pid_position_increment_controller.sv
// Discrete PID controller, incremental or positional form: operand register, then result register.
// The accepted sample item loads the operand register; the result register loads from it once the output is
// free (multiply, sum, scale and clip lie between the two registers).
// Throughput: one item per cycle; a result waiting at the output stalls intake only once
// the operand register is also full.
// Reset: all configuration, error history and the error sum clear to zero; no item held.
`timescale 1ns / 1ps
`default_nettype none

module pid_position_increment_controller import pidc_pkg::*; #(
    parameter int SAMPLE_BITS = 16
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   cfg_we,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data,
    pidc_in_if.sink                     samples,
    pidc_out_if.source                  results
);

    localparam int ERR_W  = ((SAMPLE_BITS > SET_W) ? SAMPLE_BITS : SET_W) + 1;
    localparam int DER_W  = ERR_W + 1;
    localparam int OP1_W  = (ERR_W > OUT_W) ? ERR_W : OUT_W;
    localparam int SUMX_W = OP1_W + 1;
    localparam int P0_W   = GAIN_W + ERR_W;
    localparam int P1_W   = GAIN_W + OP1_W;
    localparam int P2_W   = GAIN_W + DER_W;
    localparam int ACC_W  = GAIN_W + OP1_W + 3;

    localparam logic signed [SUMX_W-1:0] SUM_HI =
        {{(SUMX_W-OUT_W+1){1'b0}}, {(OUT_W-1){1'b1}}};
    localparam logic signed [SUMX_W-1:0] SUM_LO =
        {{(SUMX_W-OUT_W+1){1'b1}}, {(OUT_W-1){1'b0}}};
    localparam logic signed [ACC_W-1:0] ACC_HI =
        {{(ACC_W-OUT_W+1){1'b0}}, {(OUT_W-1){1'b1}}};
    localparam logic signed [ACC_W-1:0] ACC_LO =
        {{(ACC_W-OUT_W+1){1'b1}}, {(OUT_W-1){1'b0}}};
    localparam logic signed [ACC_W-1:0] ROUND_BIAS = ACC_W'((1 << GAIN_FRAC_BITS) - 1);

    // configuration
    pid_mode_t                mode_reg;
    logic signed [SET_W-1:0]  setpoint_reg;
    logic signed [GAIN_W-1:0] kp_gain_reg;
    logic signed [GAIN_W-1:0] ki_gain_reg;
    logic signed [GAIN_W-1:0] kd_gain_reg;

    // loop state
    logic signed [ERR_W-1:0]  last_error_reg;
    logic signed [ERR_W-1:0]  prior_error_reg;
    logic signed [OUT_W-1:0]  error_sum_reg;
    logic signed [ERR_W-1:0]  last_error_next;
    logic signed [ERR_W-1:0]  prior_error_next;
    logic signed [OUT_W-1:0]  error_sum_next;

    // operand stage
    logic                     v1_reg;
    pid_mode_t                mode1_reg;
    logic signed [ERR_W-1:0]  op0_reg;
    logic signed [OP1_W-1:0]  op1_reg;
    logic signed [DER_W-1:0]  op2_reg;
    logic signed [OP1_W-1:0]  op1_next;
    logic signed [DER_W-1:0]  op2_next;

    // products
    logic signed [P0_W-1:0]   p0_next;
    logic signed [P1_W-1:0]   p1_next;
    logic signed [P2_W-1:0]   p2_next;

    // output stage
    logic                     vo_reg;
    pid_mode_t                modeo_reg;
    logic signed [OUT_W-1:0]  cv_reg;
    logic                     sat_reg;
    logic signed [OUT_W-1:0]  cv_next;
    logic                     sat_next;

    logic                     out_free;
    logic                     take1;
    logic                     in_fire;
    logic signed [ERR_W-1:0]  err;
    logic signed [DER_W-1:0]  derr;
    logic signed [SUMX_W-1:0] sum_wide;
    logic signed [ACC_W-1:0]  acc;
    logic signed [ACC_W-1:0]  scaled;

    assign out_free      = !vo_reg || results.ready;
    assign take1         = !v1_reg || out_free;
    assign samples.ready = take1;
    assign in_fire       = samples.valid && take1;

    assign results.valid         = vo_reg;
    assign results.control_value = cv_reg;
    assign results.saturated     = sat_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg     <= MODE_INCREMENTAL;
            setpoint_reg <= '0;
            kp_gain_reg  <= '0;
            ki_gain_reg  <= '0;
            kd_gain_reg  <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_MODE:     mode_reg     <= pid_mode_t'(cfg_data[0]);
                REG_SETPOINT: setpoint_reg <= cfg_data;
                REG_KP_GAIN:  kp_gain_reg  <= cfg_data;
                REG_KI_GAIN:  ki_gain_reg  <= cfg_data;
                REG_KD_GAIN:  kd_gain_reg  <= cfg_data;
                default:      ;
            endcase
        end
    end

    // error, saturating sum and the three multiplicands
    always_comb
    begin
        err      = ERR_W'(setpoint_reg) - ERR_W'(samples.measurement);
        derr     = DER_W'(err) - DER_W'(last_error_reg);
        sum_wide = SUMX_W'(error_sum_reg) + SUMX_W'(err);

        if (sum_wide > SUM_HI)
            error_sum_next = OUT_W'(SUM_HI);
        else if (sum_wide < SUM_LO)
            error_sum_next = OUT_W'(SUM_LO);
        else
            error_sum_next = OUT_W'(sum_wide);

        last_error_next  = err;
        prior_error_next = prior_error_reg;
        if (mode_reg == MODE_POSITIONAL)
        begin
            op1_next = OP1_W'(error_sum_next);
            op2_next = derr;
        end
        else
        begin
            error_sum_next   = error_sum_reg;
            prior_error_next = last_error_reg;
            op1_next         = OP1_W'(last_error_reg);
            op2_next         = DER_W'(prior_error_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_error_reg  <= '0;
            prior_error_reg <= '0;
            error_sum_reg   <= '0;
        end
        else if (in_fire)
        begin
            last_error_reg  <= last_error_next;
            prior_error_reg <= prior_error_next;
            error_sum_reg   <= error_sum_next;
        end
    end

    always_comb
    begin
        p0_next = P0_W'(kp_gain_reg) * P0_W'(op0_reg);
        p1_next = P1_W'(ki_gain_reg) * P1_W'(op1_reg);
        p2_next = P2_W'(kd_gain_reg) * P2_W'(op2_reg);
    end

    // sum, divide truncating toward zero, clip
    always_comb
    begin
        if (mode1_reg == MODE_POSITIONAL)
            acc = ACC_W'(p0_next) + ACC_W'(p1_next) + ACC_W'(p2_next);
        else
            acc = ACC_W'(p0_next) - ACC_W'(p1_next) + ACC_W'(p2_next);

        if (acc < 0)
            scaled = (acc + ROUND_BIAS) >>> GAIN_FRAC_BITS;
        else
            scaled = acc >>> GAIN_FRAC_BITS;

        sat_next = 1'b1;
        if (scaled > ACC_HI)
            cv_next = OUT_W'(ACC_HI);
        else if (scaled < ACC_LO)
            cv_next = OUT_W'(ACC_LO);
        else
        begin
            cv_next  = OUT_W'(scaled);
            sat_next = 1'b0;
        end

        if (mode1_reg == MODE_POSITIONAL && cv_next < 0)
        begin
            cv_next  = '0;
            sat_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            vo_reg <= 1'b0;
        end
        else
        begin
            if (take1)
                v1_reg <= samples.valid;
            if (out_free)
                vo_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            mode1_reg <= mode_reg;
            op0_reg   <= err;
            op1_reg   <= op1_next;
            op2_reg   <= op2_next;
        end
        if (v1_reg && out_free)
        begin
            modeo_reg <= mode1_reg;
            cv_reg    <= cv_next;
            sat_reg   <= sat_next;
        end
    end

    a_pos_nonneg: assert property (@(posedge clk) disable iff (!rst_n)
        vo_reg && modeo_reg == MODE_POSITIONAL |-> !cv_reg[OUT_W-1])
        else $error("positional result below zero");

    a_inc_sum_held: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire && mode_reg == MODE_INCREMENTAL |=> $stable(error_sum_reg))
        else $error("error sum moved on incremental item");

    a_pos_prior_held: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire && mode_reg == MODE_POSITIONAL |=> $stable(prior_error_reg))
        else $error("prior error moved on positional item");

    a_last_error: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> last_error_reg == $past(err))
        else $error("last error not taken from accepted item");

    a_stage1_hold: assert property (@(posedge clk) disable iff (!rst_n)
        v1_reg && !out_free |=> v1_reg && $stable(op0_reg) && $stable(op1_reg))
        else $error("operand stage lost an item under stall");

endmodule

`default_nettype wire
